/* hdl/assert_macros.svh */
// Assertion macros shared by the checker files.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

// Checked only outside reset.
`define ASSERT_ACTIVE(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

/* hdl/ursw_pkg.sv */
// Types, constants and register defaults for the ultrasonic range wake sequencer.
// No dependencies.
`timescale 1ns / 1ps

package ursw_pkg;

   localparam int TIMER_BITS_DEF = 26;
   localparam int ECHO_BITS_DEF  = 17;

   localparam int LONG_W  = 26;
   localparam int TRIG_W  = 10;
   localparam int TOUT_W  = 16;
   localparam int DIST_W  = 19;
   localparam int INDEX_W = 3;

   localparam logic [10:0] DIST_K = 11'd1124;

   typedef enum logic [INDEX_W-1:0] {
      CSR_SETTLE,
      CSR_TRIG_LOW,
      CSR_TRIG_HIGH,
      CSR_ECHO_TIMEOUT,
      CSR_THRESHOLD,
      CSR_HOLD,
      CSR_SLEEP
   } csr_index_type;

   typedef enum logic [2:0] {
      PH_SETTLE,
      PH_TRIG_LOW,
      PH_TRIG_HIGH,
      PH_WAIT_ECHO,
      PH_TIME_ECHO,
      PH_HOLD,
      PH_SLEEP
   } phase_type;

   typedef struct packed {
      logic [LONG_W-1:0] settle_ticks;
      logic [TRIG_W-1:0] trigger_low_ticks;
      logic [TRIG_W-1:0] trigger_high_ticks;
      logic [TOUT_W-1:0] echo_timeout_ticks;
      logic [DIST_W-1:0] event_threshold_q8;
      logic [LONG_W-1:0] hold_ticks;
      logic [LONG_W-1:0] sleep_ticks;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      settle_ticks:       26'd1000000,
      trigger_low_ticks:  10'd5,
      trigger_high_ticks: 10'd15,
      echo_timeout_ticks: 16'd50000,
      event_threshold_q8: 19'd12800,
      hold_ticks:         26'd500000,
      sleep_ticks:        26'd20000000
   };

   typedef struct packed {
      logic              trigger_out;
      logic              event_out;
      logic              regulator_on;
      logic              result_valid;
      logic              timed_out;
      logic [DIST_W-1:0] distance_q8;
      logic              event_detected;
      phase_type         phase;
   } rsp_type;

endpackage

/* hdl/ursw_csr.sv */
// Configuration register file for the ultrasonic range wake sequencer.
// Depends on ursw_pkg.
`timescale 1ns / 1ps

module ursw_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [ursw_pkg::INDEX_W-1:0] csr_index,
   input  logic [ursw_pkg::LONG_W-1:0]  csr_wdata,
   output ursw_pkg::cfg_type            cfg
);

   ursw_pkg::cfg_type cfg_ff;
   ursw_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (ursw_pkg::csr_index_type'(csr_index))
            ursw_pkg::CSR_SETTLE: begin
               cfg_in.settle_ticks = csr_wdata;
            end
            ursw_pkg::CSR_TRIG_LOW: begin
               cfg_in.trigger_low_ticks = csr_wdata[ursw_pkg::TRIG_W-1:0];
            end
            ursw_pkg::CSR_TRIG_HIGH: begin
               cfg_in.trigger_high_ticks = csr_wdata[ursw_pkg::TRIG_W-1:0];
            end
            ursw_pkg::CSR_ECHO_TIMEOUT: begin
               cfg_in.echo_timeout_ticks = csr_wdata[ursw_pkg::TOUT_W-1:0];
            end
            ursw_pkg::CSR_THRESHOLD: begin
               cfg_in.event_threshold_q8 = csr_wdata[ursw_pkg::DIST_W-1:0];
            end
            ursw_pkg::CSR_HOLD: begin
               cfg_in.hold_ticks = csr_wdata;
            end
            ursw_pkg::CSR_SLEEP: begin
               cfg_in.sleep_ticks = csr_wdata;
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= ursw_pkg::CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* hdl/ursw_core.sv */
// Phase sequencer: phase, timer and echo width state, one tick per step.
// Depends on ursw_pkg.
`timescale 1ns / 1ps

module ursw_core #(
   parameter int TIMER_BITS = ursw_pkg::TIMER_BITS_DEF,
   parameter int ECHO_BITS  = ursw_pkg::ECHO_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  logic              echo,
   input  ursw_pkg::cfg_type cfg,
   output ursw_pkg::rsp_type rsp
);

   localparam int CW = ((TIMER_BITS > ursw_pkg::LONG_W) ? TIMER_BITS : ursw_pkg::LONG_W) + 1;
   localparam int PW = ECHO_BITS + 11;

   ursw_pkg::phase_type       phase_ff, phase_in;
   logic [TIMER_BITS-1:0]     timer_ff, timer_in;
   logic [ECHO_BITS-1:0]      width_ff, width_in;

   logic [TIMER_BITS:0]       t_inc;
   logic [ECHO_BITS:0]        w_inc;
   logic [PW-1:0]             prod;
   logic [ursw_pkg::LONG_W-1:0] dur_sel;
   logic                      timed_done;
   logic                      wait_tout;
   logic                      w_tout;
   logic                      first_tout;
   logic                      done;
   logic                      tout;
   logic                      ev;
   logic [ursw_pkg::DIST_W-1:0] dist_q8;

   assign t_inc = (TIMER_BITS+1)'(timer_ff) + (TIMER_BITS+1)'(1);
   assign w_inc = (ECHO_BITS+1)'(width_ff) + (ECHO_BITS+1)'(1);
   assign prod  = PW'(width_ff) * PW'(ursw_pkg::DIST_K);

   always_comb begin
      case (phase_ff)
         ursw_pkg::PH_SETTLE:    dur_sel = cfg.settle_ticks;
         ursw_pkg::PH_TRIG_LOW:  dur_sel = ursw_pkg::LONG_W'(cfg.trigger_low_ticks);
         ursw_pkg::PH_TRIG_HIGH: dur_sel = ursw_pkg::LONG_W'(cfg.trigger_high_ticks);
         ursw_pkg::PH_HOLD:      dur_sel = cfg.hold_ticks;
         ursw_pkg::PH_SLEEP:     dur_sel = cfg.sleep_ticks;
         default:                dur_sel = '0;
      endcase
   end

   assign timed_done = (CW'(t_inc) >= CW'(dur_sel)) || t_inc[TIMER_BITS];
   assign wait_tout  = CW'(t_inc) > CW'(cfg.echo_timeout_ticks);
   assign w_tout     = (CW'(w_inc) > CW'(cfg.echo_timeout_ticks)) || w_inc[ECHO_BITS];
   assign first_tout = (cfg.echo_timeout_ticks == '0);

   // next state
   always_comb begin
      phase_in = phase_ff;
      timer_in = timer_ff;
      width_in = width_ff;
      done     = 1'b0;
      tout     = 1'b0;
      dist_q8  = '0;
      ev       = 1'b0;
      case (phase_ff)
         ursw_pkg::PH_SETTLE, ursw_pkg::PH_TRIG_LOW, ursw_pkg::PH_HOLD,
         ursw_pkg::PH_SLEEP: begin
            if (timed_done) begin
               timer_in = '0;
               case (phase_ff)
                  ursw_pkg::PH_SETTLE:   phase_in = ursw_pkg::PH_TRIG_LOW;
                  ursw_pkg::PH_TRIG_LOW: phase_in = ursw_pkg::PH_TRIG_HIGH;
                  ursw_pkg::PH_HOLD:     phase_in = ursw_pkg::PH_SLEEP;
                  default:               phase_in = ursw_pkg::PH_SETTLE;
               endcase
            end else begin
               timer_in = t_inc[TIMER_BITS-1:0];
            end
         end
         ursw_pkg::PH_TRIG_HIGH: begin
            if (timed_done) begin
               phase_in = ursw_pkg::PH_WAIT_ECHO;
               timer_in = '0;
               width_in = '0;
            end else begin
               timer_in = t_inc[TIMER_BITS-1:0];
            end
         end
         ursw_pkg::PH_WAIT_ECHO: begin
            if (echo) begin
               // rising sample is the first high tick
               phase_in = ursw_pkg::PH_TIME_ECHO;
               timer_in = '0;
               if (first_tout) begin
                  done     = 1'b1;
                  tout     = 1'b1;
                  width_in = '0;
               end else begin
                  width_in = ECHO_BITS'(1);
               end
            end else if (wait_tout) begin
               done = 1'b1;
               tout = 1'b1;
            end else begin
               timer_in = t_inc[TIMER_BITS-1:0];
            end
         end
         ursw_pkg::PH_TIME_ECHO: begin
            if (echo) begin
               if (w_tout) begin
                  done = 1'b1;
                  tout = 1'b1;
               end else begin
                  width_in = w_inc[ECHO_BITS-1:0];
               end
            end else begin
               done    = 1'b1;
               dist_q8 = prod[ursw_pkg::DIST_W+7:8];
            end
         end
         default: begin
            phase_in = ursw_pkg::PH_SETTLE;
            timer_in = '0;
         end
      endcase
      if (done) begin
         ev       = !tout && (dist_q8 != '0) && (dist_q8 < cfg.event_threshold_q8);
         phase_in = ev ? ursw_pkg::PH_HOLD : ursw_pkg::PH_SLEEP;
         timer_in = '0;
         width_in = '0;
      end
   end

   // outputs
   always_comb begin
      rsp.trigger_out    = (phase_in == ursw_pkg::PH_TRIG_HIGH);
      rsp.event_out      = (phase_in == ursw_pkg::PH_HOLD);
      rsp.regulator_on   = (phase_in != ursw_pkg::PH_SLEEP);
      rsp.result_valid   = done;
      rsp.timed_out      = tout;
      rsp.distance_q8    = dist_q8;
      rsp.event_detected = ev;
      rsp.phase          = phase_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= ursw_pkg::PH_SETTLE;
         timer_ff <= '0;
         width_ff <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         timer_ff <= timer_in;
         width_ff <= width_in;
      end
   end

endmodule

/* hdl/ultrasonic_range_wake_sequencer.sv */
// Top level of the ultrasonic range wake sequencer: input and result registers
// around the phase sequencer. Depends on ursw_pkg, ursw_csr, ursw_core.
//
//  channel | direction | handshake          | payload
//  req     | in        | req_valid/stall    | req_echo_level
//  rsp     | out       | rsp_valid/stall    | trigger, event, regulator, result, phase
//  csr     | in        | csr_valid/ready    | csr_index, csr_wdata
//
// One item per cycle while the result register is not stalled; the result
// register is loaded from the input register, and rsp_valid rises as it is loaded.
// Each item advances the sequencer by one microsecond tick between the input
// register and the result register.
// Reset clears both valid flags and the sequencer; CSRs take their defaults.
// rsp_stall holds the result register; the input register still takes one more
// item, and req_stall rises only when both registers are full.
`timescale 1ns / 1ps

module ultrasonic_range_wake_sequencer #(
   parameter int TIMER_BITS = ursw_pkg::TIMER_BITS_DEF,
   parameter int ECHO_BITS  = ursw_pkg::ECHO_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_echo_level,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_trigger_out,
   output logic                         rsp_event_out,
   output logic                         rsp_regulator_on,
   output logic                         rsp_result_valid,
   output logic                         rsp_timed_out,
   output logic [ursw_pkg::DIST_W-1:0]  rsp_distance_q8,
   output logic                         rsp_event_detected,
   output logic [2:0]                   rsp_phase,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [ursw_pkg::INDEX_W-1:0] csr_index,
   input  logic [ursw_pkg::LONG_W-1:0]  csr_wdata
);

   ursw_pkg::cfg_type cfg;
   ursw_pkg::rsp_type core_rsp;

   logic              in_valid_ff, in_valid_in;
   logic              in_echo_ff, in_echo_in;
   logic              out_valid_ff, out_valid_in;
   ursw_pkg::rsp_type out_ff, out_in;
   logic              adv;
   logic              req_take;

   ursw_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ursw_core #(
      .TIMER_BITS (TIMER_BITS),
      .ECHO_BITS  (ECHO_BITS)
   ) u_core (
      .clock (clock),
      .reset (reset),
      .step  (adv),
      .echo  (in_echo_ff),
      .cfg   (cfg),
      .rsp   (core_rsp)
   );

   assign adv       = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !adv;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_echo_in  = in_echo_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         in_echo_in  = req_echo_level;
      end else if (adv) begin
         in_valid_in = 1'b0;
      end
      out_in = out_ff;
      if (adv) begin
         out_valid_in = 1'b1;
         out_in       = core_rsp;
      end else begin
         out_valid_in = out_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_echo_ff <= in_echo_in;
      out_ff     <= out_in;
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_trigger_out    = out_ff.trigger_out;
   assign rsp_event_out      = out_ff.event_out;
   assign rsp_regulator_on   = out_ff.regulator_on;
   assign rsp_result_valid   = out_ff.result_valid;
   assign rsp_timed_out      = out_ff.timed_out;
   assign rsp_distance_q8    = out_ff.distance_q8;
   assign rsp_event_detected = out_ff.event_detected;
   assign rsp_phase          = out_ff.phase;

endmodule

/* hdl/ursw_checker.sv */
// Port-level checks for the ultrasonic range wake sequencer, bound to the top.
// Depends on ursw_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ursw_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_stall,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic                         rsp_result_valid,
   input logic [ursw_pkg::DIST_W-1:0]  rsp_distance_q8,
   input logic                         rsp_event_detected,
   input logic [2:0]                   rsp_phase
);

   `ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid && !req_stall, "not empty after reset")

   `ASSERT_ACTIVE(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_phase) && $stable(rsp_distance_q8), "stalled item changed")

   `ASSERT_ACTIVE(a_stall_cause, clock, reset, req_stall |-> rsp_valid && rsp_stall, "input stalled without output backpressure")

   `ASSERT_ACTIVE(a_result_phase, clock, reset, rsp_valid && rsp_result_valid |-> rsp_event_detected == (rsp_phase == 3'(ursw_pkg::PH_HOLD)) && (rsp_event_detected || rsp_phase == 3'(ursw_pkg::PH_SLEEP)), "result not followed by hold or sleep")

endmodule

bind ultrasonic_range_wake_sequencer ursw_checker u_checker (.*);
